### rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Shared item types, function codes, segment table and BCD conversion helpers.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Default digit count of the display
    localparam int NUM_DIGITS_DEF = 4;

    // Width of the digit enable field on the result side
    localparam int ENABLE_W = 4;

    // BCD digits needed for a 16-bit binary value
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Function codes
    localparam logic [1:0] FUNC_NUMBER = 2'd0;
    localparam logic [1:0] FUNC_TIME   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] number;
        logic [6:0]  minutes;
        logic [5:0]  seconds;
    } t_in_item;

    typedef struct packed {
        logic                drive_valid;
        logic [ENABLE_W-1:0] digit_enable;
        logic [7:0]          segment_pattern;
        logic                rejected;
    } t_out_item;

    // Classified and converted command handed from front to back
    typedef struct packed {
        logic [1:0]       kind;
        logic [BCD_W-1:0] bcd;
        logic             reject;
    } t_cmd;

    // Power of ten, used at elaboration only
    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // Eight shift-add-3 steps of a binary to BCD conversion
    function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
                                                  input logic [7:0]       bits);
        logic [BCD_W-1:0] b;
        b = bcd_in;
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < BCD_DIGITS; k++) begin
                if (b[4*k +: 4] >= 4'd5) begin
                    b[4*k +: 4] = b[4*k +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[7-i]};
        end
        return b;
    endfunction

    // Active-high segments a..g for one decimal digit
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'b0111111;
            4'd1:    s = 7'b0000110;
            4'd2:    s = 7'b1011011;
            4'd3:    s = 7'b1001111;
            4'd4:    s = 7'b1100110;
            4'd5:    s = 7'b1101101;
            4'd6:    s = 7'b1111101;
            4'd7:    s = 7'b0000111;
            4'd8:    s = 7'b1111111;
            4'd9:    s = 7'b1101111;
            default: s = 7'b0000000;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/ssd_if.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver channels
// Valid/ready stream interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface ssd_in_if
    import ssd_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ssd_out_if
    import ssd_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/ssd_front.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver front end
// Classifies items, range-checks numbers and converts values to BCD.
// ----------------------------------------------------------------------------
module ssd_front
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_cmd     o_cmd
);

    localparam logic [31:0] LIMIT = pow10(NUM_DIGITS);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        reject;
    } t_pre;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BCD_W-1:0] bcd;
        logic [7:0]       low;
        logic             reject;
    } t_mid;

    logic r_a_valid, r_b_valid;
    t_pre r_a, n_a;
    t_mid r_b, n_b;
    logic a_ready, b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A: classify, build the value and range check
    always_comb begin
        n_a.kind   = i_item.func;
        n_a.value  = (i_item.func == FUNC_TIME)
                   ? 16'(16'(i_item.minutes) * 16'd100 + 16'(i_item.seconds))
                   : i_item.number;
        n_a.reject = (i_item.func == FUNC_NUMBER) && ({16'd0, i_item.number} >= LIMIT);
    end

    // Stage B: convert the upper byte
    always_comb begin
        n_b.kind   = r_a.kind;
        n_b.reject = r_a.reject;
        n_b.bcd    = dabble8('0, r_a.value[15:8]);
        n_b.low    = r_a.value[7:0];
    end

    // Output: finish with the lower byte
    always_comb begin
        o_cmd.kind   = r_b.kind;
        o_cmd.reject = r_b.reject;
        o_cmd.bcd    = dabble8(r_b.bcd, r_b.low);
    end
    assign o_valid = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= n_a;
        end
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

endmodule

### rtl/core/ssd_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ssd_queue
    import ssd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/ssd_back.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver back end
// Applies commands to the digit store and produces the scan results.
// ----------------------------------------------------------------------------
module ssd_back
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [3:0]        r_digit [NUM_DIGITS];
    logic [3:0]        n_digit [NUM_DIGITS];
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              pop, do_store;
    logic [3:0]        cur_digit;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    // Load the store on an accepted number or on any time value
    assign do_store = (i_cmd.kind == FUNC_TIME)
                   || ((i_cmd.kind == FUNC_NUMBER) && !i_cmd.reject);

    // Leftmost digit takes the highest place; places beyond the BCD word are zero
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (NUM_DIGITS - 1 - i < BCD_DIGITS) begin
                n_digit[i] = i_cmd.bcd[4*(NUM_DIGITS-1-i) +: 4];
            end else begin
                n_digit[i] = 4'd0;
            end
        end
    end

    assign cur_digit = r_digit[r_scan];
    assign n_scan    = (r_scan == SCAN_W'(NUM_DIGITS - 1)) ? '0 : r_scan + 1'b1;

    always_comb begin
        n_out = '0;
        unique case (i_cmd.kind)
            FUNC_NUMBER: n_out.rejected = i_cmd.reject;
            FUNC_TIME:   n_out = '0;
            FUNC_TICK: begin
                n_out.drive_valid     = 1'b1;
                n_out.digit_enable    = ENABLE_W'(4'b0001) << r_scan;
                n_out.segment_pattern = {1'b0, seg_of(cur_digit)};
            end
            default:     n_out = '0;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit[i] <= 4'd0;
            end
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (pop && do_store) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    r_digit[i] <= n_digit[i];
                end
            end
            if (pop && (i_cmd.kind == FUNC_TICK)) begin
                r_scan <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_W'(NUM_DIGITS - 1))
        else $error("scan position beyond last digit");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && (i_cmd.kind == FUNC_TICK)) |=> $stable(r_scan))
        else $error("scan position moved without a tick");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.drive_valid && r_out.rejected))
        else $error("drive and reject flagged together");

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.digit_enable)
                     && (r_out.drive_valid || (r_out.digit_enable == '0)))
        else $error("digit enable not one-hot or set without a drive");
`endif

endmodule

### rtl/core/seven_segment_scan_driver.sv
// Path: an item passes front stages A and B, the command queue and the output register.
// Throughput: one item per cycle without back-pressure; the front pipeline, queue and
// output register advance unless stalled, so set and tick items may follow back to back.
// Reset: synchronous, active low; clears the digit store to zeros, the scan position,
// the queue and all valid flags. No clearing pass; items are taken right after reset.
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Multiplexed display driver: stores numbers or mm:ss times as decimal digits and
// emits one digit enable and segment pattern per refresh tick.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssd_in_if.sink      i_in,
    ssd_out_if.source   o_out
);

    // Front to queue
    logic front_valid, front_ready;
    t_cmd front_cmd;

    // Queue to back
    logic queue_valid, queue_ready;
    t_cmd queue_cmd;

    // Front: classify the transfer, range check set-number values, build
    // minutes*100+seconds for set-time items and convert to BCD over two stages.
    ssd_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.payload),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_cmd   (front_cmd)
    );

    // Queue: absorb back-end stalls so the front keeps moving.
    ssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_cmd   (queue_cmd)
    );

    // Back: update the digit store, decode the digit under the scan position on
    // a tick, advance the scan and hold each result in the output register.
    ssd_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_cmd   (queue_cmd),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.payload)
    );

endmodule
